@@ hdl/meg_pkg.sv @@
// shared types and constants for the mouse event generator
package meg_pkg;

    localparam int COORD_W     = 16;
    localparam int BTN_W       = 3;
    localparam int NUM_BUTTONS = 3;
    localparam int BTN_USED    = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
    localparam logic [BTN_W-1:0] BTN_USED_MASK = BTN_W'((1 << BTN_USED) - 1);

    localparam int MEG_QUEUE_DEPTH = 2;

    localparam logic [COORD_W-1:0] PREV_RESET  = '1;
    localparam logic [COORD_W-1:0] TOP_X_RESET = 16'd1023;
    localparam logic [COORD_W-1:0] TOP_Y_RESET = 16'd767;

    typedef enum logic [1:0] {
        EV_MOVE  = 2'd0,
        EV_DOWN  = 2'd1,
        EV_UP    = 2'd2,
        EV_CLICK = 2'd3
    } t_ev_kind;

    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_index;

    // one classified sample, handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   btn;
        logic               move;
        logic [BTN_W-1:0]   down;
        logic [BTN_W-1:0]   up;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
    } t_job;

endpackage

@@ hdl/meg_front.sv @@
// front part: config registers, sample classification and tracked state
module meg_front
    import meg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [BTN_W-1:0]   i_button_bits,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output t_job               o_job
);

    logic [COORD_W-1:0] r_top_x, r_top_y;
    logic [COORD_W-1:0] r_prev_x, r_prev_y;
    logic [BTN_W-1:0]   r_prev_btn;
    logic [COORD_W-1:0] r_cur_x, r_cur_y;
    logic [COORD_W-1:0] n_top;
    logic [COORD_W-1:0] clamp_x, clamp_y;
    logic [BTN_W-1:0]   changed;
    logic               move;
    logic               accept;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W-1:0] top
    );
        logic [COORD_W-1:0] r;
        if (v[COORD_W-1]) begin
            r = '0;
        end else if (v > top) begin
            r = top;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // a size of zero behaves as one
    assign n_top = (i_cfg_data == '0) ? '0 : i_cfg_data - COORD_W'(1);

    assign move    = (i_pos_x != r_prev_x) || (i_pos_y != r_prev_y);
    assign changed = (i_button_bits ^ r_prev_btn) & BTN_USED_MASK;
    assign clamp_x = clamp_coord(i_pos_x, r_top_x);
    assign clamp_y = clamp_coord(i_pos_y, r_top_y);

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_job.x     = i_pos_x;
        o_job.y     = i_pos_y;
        o_job.btn   = i_button_bits;
        o_job.move  = move;
        o_job.down  = changed & i_button_bits;
        o_job.up    = changed & ~i_button_bits;
        o_job.cur_x = move ? clamp_x : r_cur_x;
        o_job.cur_y = move ? clamp_y : r_cur_y;
    end

    // samples with nothing to report leave no trace in the queue
    assign o_push = accept && (move || (changed != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_x    <= TOP_X_RESET;
            r_top_y    <= TOP_Y_RESET;
            r_prev_x   <= PREV_RESET;
            r_prev_y   <= PREV_RESET;
            r_prev_btn <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SCREEN_WIDTH:  r_top_x <= n_top;
                    CFG_SCREEN_HEIGHT: r_top_y <= n_top;
                    default:           r_top_x <= r_top_x;
                endcase
            end
            if (accept) begin
                r_prev_btn <= i_button_bits;
                if (move) begin
                    r_prev_x <= i_pos_x;
                    r_prev_y <= i_pos_y;
                    r_cur_x  <= clamp_x;
                    r_cur_y  <= clamp_y;
                end
            end
        end
    end

endmodule

@@ hdl/meg_queue.sv @@
// short job queue between front and back
module meg_queue
    import meg_pkg::*;
#(
    parameter int QUEUE_DEPTH = MEG_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/meg_back.sv @@
// back part: expands one job into its events, output register
module meg_back
    import meg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_event_kind,
    output logic [COORD_W-1:0] o_event_x,
    output logic [COORD_W-1:0] o_event_y,
    output logic [BTN_W-1:0]   o_event_buttons,
    output logic [COORD_W-1:0] o_cursor_x,
    output logic [COORD_W-1:0] o_cursor_y,
    output logic               o_last_of_run
);

    t_job             r_job;
    logic             r_busy;
    logic             r_mv;
    logic [BTN_W-1:0] r_dn, r_ck, r_up;
    logic             r_out_valid;
    t_ev_kind         r_kind;
    logic [BTN_W-1:0] r_btn;
    logic [COORD_W-1:0] r_x, r_y, r_cx, r_cy;
    logic             r_last;

    t_ev_kind         sel_kind;
    logic [BTN_W-1:0] sel_mask;
    logic             n_mv;
    logic [BTN_W-1:0] n_dn, n_ck, n_up;
    logic             sel_last;
    logic             found;
    logic             out_load;

    // pick the next pending event: move first, then buttons low to high
    always_comb begin
        sel_kind = EV_MOVE;
        sel_mask = r_job.btn;
        n_mv     = r_mv;
        n_dn     = r_dn;
        n_ck     = r_ck;
        n_up     = r_up;
        found    = 1'b0;
        if (r_mv) begin
            n_mv = 1'b0;
        end else begin
            for (int i = 0; i < BTN_W; i++) begin
                if (!found && (r_dn[i] || r_ck[i] || r_up[i])) begin
                    found    = 1'b1;
                    sel_mask = BTN_W'(1) << i;
                    if (r_dn[i]) begin
                        sel_kind = EV_DOWN;
                        n_dn[i]  = 1'b0;
                    end else if (r_ck[i]) begin
                        sel_kind = EV_CLICK;
                        n_ck[i]  = 1'b0;
                    end else begin
                        sel_kind = EV_UP;
                        n_up[i]  = 1'b0;
                    end
                end
            end
        end
        sel_last = !n_mv && (n_dn == '0) && (n_ck == '0) && (n_up == '0);
    end

    assign out_load = r_busy && (!r_out_valid || i_ready);
    assign o_pop    = !i_q_empty && (!r_busy || (out_load && sel_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mv        <= 1'b0;
            r_dn        <= '0;
            r_ck        <= '0;
            r_up        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_mv   <= i_job.move;
                r_dn   <= i_job.down;
                r_ck   <= i_job.down;
                r_up   <= i_job.up;
            end else if (out_load) begin
                r_busy <= !sel_last;
                r_mv   <= n_mv;
                r_dn   <= n_dn;
                r_ck   <= n_ck;
                r_up   <= n_up;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_kind <= sel_kind;
            r_btn  <= sel_mask;
            r_x    <= r_job.x;
            r_y    <= r_job.y;
            r_cx   <= r_job.cur_x;
            r_cy   <= r_job.cur_y;
            r_last <= sel_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_kind;
    assign o_event_x       = r_x;
    assign o_event_y       = r_y;
    assign o_event_buttons = r_btn;
    assign o_cursor_x      = r_cx;
    assign o_cursor_y      = r_cy;
    assign o_last_of_run   = r_last;

endmodule

@@ hdl/mouse_event_generator.sv @@
// top level of the mouse event generator
//
// input channel (i_valid / o_ready) takes one pointer sample per item:
// signed position, three button bits and a change hint that is ignored
// output channel (o_valid / i_ready) gives one event per item: move, button
// down, button up or click, with the sample position, the clamped cursor
// and a flag on the last event of the sample
// the front classifies each sample in the cycle it is taken and drops
// samples with nothing to report; the rest go into a short job queue
// the back expands a job into its events, one per cycle while the receiver
// is ready, into an output register; a sample gives 1 to 7 events
// the first event of a sample passes the queue, the back's job register and
// the output register before it is valid
// unstalled rate is one event per cycle, limited by the single output port
// a stalled receiver holds the output register; the back then waits and
// the front keeps taking samples until the queue is full
// reset (synchronous, active low) sets the screen to 1024 x 768, the last
// position to minus one in both axes, buttons and cursor to zero, and
// empties queue and output
// config writes (i_cfg_wr_en) take effect at once; write only when idle
module mouse_event_generator
    import meg_pkg::*;
#(
    parameter int QUEUE_DEPTH = MEG_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_data,
    // sample channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [BTN_W-1:0]   i_button_bits,
    input  logic               i_change_hint,
    // event channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_event_kind,
    output logic [COORD_W-1:0] o_event_x,
    output logic [COORD_W-1:0] o_event_y,
    output logic [BTN_W-1:0]   o_event_buttons,
    output logic [COORD_W-1:0] o_cursor_x,
    output logic [COORD_W-1:0] o_cursor_y,
    output logic               o_last_of_run
);

    logic q_push, q_pop, q_full, q_empty;
    t_job push_job, pop_job;

    // i_change_hint carries no meaning for the events and is not used

    // classification and position / button / cursor tracking
    meg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_button_bits (i_button_bits),
        .i_q_full      (q_full),
        .o_ready       (o_ready),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    // decouples sample intake from event output
    meg_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    // event sequencer and output register
    meg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_job           (pop_job),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_kind    (o_event_kind),
        .o_event_x       (o_event_x),
        .o_event_y       (o_event_y),
        .o_event_buttons (o_event_buttons),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

@@ tb/mouse_event_generator_tb.sv @@
// self-checking testbench for the mouse event generator, scoreboard class and drive tasks
`timescale 1ns / 1ps

module mouse_event_generator_tb;
    import meg_pkg::*;

    // stall cycles with no item moving on either channel before giving up
    localparam int STUCK_LIMIT = 4000;
    // quiet cycles after the last event before a screen size write
    localparam int SETTLE_CYCLES = 8;

    // one event as seen on the output channel
    typedef struct packed {
        t_ev_kind           kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   btn;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic               last;
    } t_mouse_event;

    // tracks pointer state, predicts the events of each sample and matches them in order
    class event_scoreboard;
        logic [COORD_W-1:0] scr_w;
        logic [COORD_W-1:0] scr_h;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [BTN_W-1:0]   last_btn;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        t_mouse_event       due[$];
        int                 mismatches;
        int                 samples;
        int                 kind_count[4];

        function new();
            scr_w      = 16'd1024;
            scr_h      = 16'd768;
            last_x     = '1;
            last_y     = '1;
            last_btn   = '0;
            cur_x      = '0;
            cur_y      = '0;
            mismatches = 0;
            samples    = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [COORD_W-1:0] val);
            if (idx == CFG_SCREEN_WIDTH) scr_w = val;
            else scr_h = val;
        endfunction

        // zero size behaves as one, so the cursor pins at zero
        function logic [COORD_W-1:0] clamp(logic signed [COORD_W-1:0] v,
                                           logic [COORD_W-1:0] size);
            int top;
            top = (size == 0) ? 0 : int'(size) - 1;
            if (v < 0) return '0;
            if (int'(v) > top) return COORD_W'(top);
            return v;
        endfunction

        function void note_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [BTN_W-1:0] btn);
            t_ev_kind         kinds[7];
            logic [BTN_W-1:0] masks[7];
            logic [BTN_W-1:0] flipped;
            logic [BTN_W-1:0] mask;
            t_mouse_event     ev;
            int               n;
            n = 0;
            samples++;
            if (x != last_x || y != last_y) begin
                cur_x = clamp(x, scr_w);
                cur_y = clamp(y, scr_h);
                kinds[n] = EV_MOVE;
                masks[n] = btn;
                n++;
                last_x = x;
                last_y = y;
            end
            flipped = btn ^ last_btn;
            for (int i = 0; i < NUM_BUTTONS && i < BTN_W; i++) begin
                mask = BTN_W'(1 << i);
                if (flipped[i]) begin
                    if (btn[i]) begin
                        kinds[n] = EV_DOWN;
                        masks[n] = mask;
                        n++;
                        kinds[n] = EV_CLICK;
                        masks[n] = mask;
                        n++;
                    end else begin
                        kinds[n] = EV_UP;
                        masks[n] = mask;
                        n++;
                    end
                end
            end
            last_btn = btn;
            for (int i = 0; i < n; i++) begin
                ev.kind  = kinds[i];
                ev.x     = x;
                ev.y     = y;
                ev.btn   = masks[i];
                ev.cur_x = cur_x;
                ev.cur_y = cur_y;
                ev.last  = (i == n - 1);
                due.push_back(ev);
            end
        endfunction

        function void check_event(t_mouse_event got);
            t_mouse_event want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d x %h y %h btn %b cur %0d,%0d last %b",
                             got.kind, got.x, got.y, got.btn, got.cur_x, got.cur_y, got.last);
                return;
            end
            want = due.pop_front();
            kind_count[want.kind]++;
            if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
                got.btn !== want.btn || got.cur_x !== want.cur_x ||
                got.cur_y !== want.cur_y || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("event mismatch at %0t", $realtime);
                    $display("  expected kind %0d x %h y %h btn %b cur %0d,%0d last %b",
                             want.kind, want.x, want.y, want.btn, want.cur_x, want.cur_y,
                             want.last);
                    $display("  actual   kind %0d x %h y %h btn %b cur %0d,%0d last %b",
                             got.kind, got.x, got.y, got.btn, got.cur_x, got.cur_y, got.last);
                end
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic               i_cfg_index   = 1'b0;
    logic [COORD_W-1:0] i_cfg_data    = '0;
    logic               i_valid       = 1'b0;
    logic [COORD_W-1:0] i_pos_x       = '0;
    logic [COORD_W-1:0] i_pos_y       = '0;
    logic [BTN_W-1:0]   i_button_bits = '0;
    logic               i_change_hint = 1'b0;
    logic               i_ready       = 1'b0;

    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_event_kind;
    logic [COORD_W-1:0] o_event_x;
    logic [COORD_W-1:0] o_event_y;
    logic [BTN_W-1:0]   o_event_buttons;
    logic [COORD_W-1:0] o_cursor_x;
    logic [COORD_W-1:0] o_cursor_y;
    logic               o_last_of_run;

    event_scoreboard sb = new();

    // last sample sent, so the random part can hold the position still
    logic [COORD_W-1:0] sent_x   = '1;
    logic [COORD_W-1:0] sent_y   = '1;
    logic [BTN_W-1:0]   sent_btn = '0;
    // while set, neither side idles
    bit                 steady   = 1'b0;
    int                 stuck_cycles = 0;
    int                 screens  = 1;

    mouse_event_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_button_bits  (i_button_bits),
        .i_change_hint  (i_change_hint),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_event_x      (o_event_x),
        .o_event_y      (o_event_y),
        .o_event_buttons(o_event_buttons),
        .o_cursor_x     (o_cursor_x),
        .o_cursor_y     (o_cursor_y),
        .o_last_of_run  (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // receiver stalls at random, with a chance of 8 in a hundred, never while steady
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // every accepted event goes straight to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_event('{kind: t_ev_kind'(o_event_kind), x: o_event_x, y: o_event_y,
                             btn: o_event_buttons, cur_x: o_cursor_x, cur_y: o_cursor_y,
                             last: o_last_of_run});
        end
    end

    // cycles in which nothing moves on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // watchdog: a hang ends the run as a failure
    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
        $display("mouse_event_generator_tb: done, errors");
        $finish;
    end

    // one sample on the input channel; returns at the edge that takes it
    task automatic send_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [BTN_W-1:0] btn, logic hint);
        if (!steady && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_button_bits <= btn;
        i_change_hint <= hint;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(x, y, btn);
        sent_x   = x;
        sent_y   = y;
        sent_btn = btn;
    endtask

    // drop valid after the last item of a phase, let events drain, then settle
    task automatic drain;
        i_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both screen registers, written back to back while the block is idle
    task automatic set_screen(logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        sb.write_reg(CFG_SCREEN_WIDTH, w);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        sb.write_reg(CFG_SCREEN_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
        screens++;
    endtask

    // coordinates that sit on a clamp boundary or a range extreme
    function automatic logic [COORD_W-1:0] edge_coord(logic [COORD_W-1:0] size);
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return size - 16'd1;
            5: return size;
            default: return size + 16'd1;
        endcase
    endfunction

    // random samples: held positions for button-only runs, moves on and off
    // the screen, full-range noise and clamp edges; buttons often held
    task automatic run_random(int count);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   b;
        int                 pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                x = sent_x;
                y = sent_y;
            end else if (pick < 55) begin
                x = COORD_W'($urandom_range(0, 1200)) - 16'd60;
                y = COORD_W'($urandom_range(0, 900)) - 16'd60;
            end else if (pick < 80) begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end else begin
                x = edge_coord(sb.scr_w);
                y = edge_coord(sb.scr_h);
            end
            b = ($urandom_range(0, 99) < 40) ? sent_btn : BTN_W'($urandom);
            send_sample(x, y, b, 1'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset screen of 1024 x 768
        // sample at minus one straight after reset: no move event
        send_sample(16'hffff, 16'hffff, 3'b000, 1'b0);
        // nothing changed, hint raised: still nothing
        send_sample(16'hffff, 16'hffff, 3'b000, 1'b1);
        // left press without a move
        send_sample(16'hffff, 16'hffff, 3'b001, 1'b0);
        send_sample(16'h0000, 16'h0000, 3'b001, 1'b0);
        // far positive corner clamps to the screen edge
        send_sample(16'h7fff, 16'h7fff, 3'b001, 1'b1);
        // far negative corner clamps to zero, right press
        send_sample(16'h8000, 16'h8000, 3'b011, 1'b0);
        send_sample(16'h8000, 16'h8000, 3'b111, 1'b0);
        // move with all three released
        send_sample(16'd100, 16'd200, 3'b000, 1'b1);
        // all three pressed at once
        send_sample(16'd100, 16'd200, 3'b111, 1'b0);
        send_sample(16'd1023, 16'd767, 3'b000, 1'b0);
        // one past the screen edge, move plus three presses: seven events
        send_sample(16'd1024, 16'd768, 3'b111, 1'b1);
        send_sample(16'hffff, 16'd5, 3'b101, 1'b0);
        send_sample(16'd5, 16'hffff, 3'b010, 1'b1);
        send_sample(16'h7fff, 16'h8000, 3'b010, 1'b1);
        send_sample(16'h5555, 16'haaaa, 3'b101, 1'b0);
        send_sample(16'haaaa, 16'h5555, 3'b010, 1'b1);
        send_sample(16'hffff, 16'hffff, 3'b000, 1'b0);
        run_random(100);
        drain();

        // one pixel screen: cursor pinned at zero
        set_screen(16'd1, 16'd1);
        run_random(60);
        drain();

        // widest screen, and a stretch with no idling on either side
        set_screen(16'hffff, 16'hffff);
        steady = 1'b1;
        run_random(100);
        steady = 1'b0;
        drain();

        // zero size acts as one
        set_screen(16'd0, 16'd0);
        run_random(60);
        drain();

        set_screen(COORD_W'($urandom_range(1, 65535)), COORD_W'($urandom_range(1, 65535)));
        run_random(80);
        drain();

        set_screen(16'd640, 16'd480);
        run_random(80);
        drain();

        $display("covered %0d samples over %0d screen sizes, including zero, one and 65535",
                 sb.samples, screens);
        $display("events checked: %0d moves, %0d downs, %0d ups, %0d clicks, %0d mismatches",
                 sb.kind_count[EV_MOVE], sb.kind_count[EV_DOWN], sb.kind_count[EV_UP],
                 sb.kind_count[EV_CLICK], sb.mismatches);
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("mouse_event_generator_tb: done, clean");
        end else begin
            $display("mouse_event_generator_tb: done, errors");
        end
        $finish;
    end

endmodule
